// File: hw/rtl/twma_pkg.sv
// package for the time window moving average block
// types and constants shared by the controller, datapath and divider
`default_nettype none
package twma_pkg;

    localparam int DataW = 32;
    localparam int SumW  = 42;
    localparam int CntW  = 10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STORE,
        ST_EVICT_RD,
        ST_EVICT_WAIT,
        ST_EVICT_CHK,
        ST_SCAN_INIT,
        ST_SCAN_RD,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;      // capture input item
        logic store;       // write ring, add sample, advance write pointer
        logic rd_oldest;   // read entry at oldest pointer
        logic evict;       // subtract oldest and advance
        logic clear;       // clear pointers and sum
        logic scan_start;  // start min/max scan
        logic scan_step;   // read next scan entry
        logic div_start;
        logic finish;      // load output register
    } cmd_t;

    typedef struct packed {
        logic ring_full;
        logic period_zero;
        logic evict_ok;    // window not empty and difference >= period
        logic empty;
        logic scan_done;
        logic div_done;
    } stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/twma_div.sv
// serial signed divider: 42-bit dividend over unsigned count, one bit a cycle
// uses twma_pkg
`default_nettype none
module twma_div #(
    parameter int CW = 10
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [twma_pkg::SumW-1:0] dividend,
    input  wire logic [CW-1:0]           divisor,
    output logic                         done,
    output logic [twma_pkg::SumW-1:0]    quotient
);
    import twma_pkg::*;

    localparam int BitW = $clog2(SumW + 1);

    logic [SumW-1:0] q_reg, q_next;
    logic [SumW:0]   r_reg, r_next;
    logic [BitW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            neg_reg, neg_next;
    logic [SumW:0]   trial;

    assign trial = {r_reg[SumW-1:0], q_reg[SumW-1]} - {{(SumW+1-CW){1'b0}}, divisor};

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            neg_next  = dividend[SumW-1];
            q_next    = dividend[SumW-1] ? (~dividend + 1'b1) : dividend;
            r_next    = '0;
            cnt_next  = BitW'(SumW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[SumW])
            begin
                r_next = trial;
                q_next = {q_reg[SumW-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[SumW-1:0], q_reg[SumW-1]};
                q_next = {q_reg[SumW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == BitW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        neg_reg <= neg_next;
    end

    assign done     = !busy_reg && !start;
    assign quotient = neg_reg ? (~q_reg + 1'b1) : q_reg;

endmodule
`default_nettype wire

// File: hw/rtl/twma_ctrl.sv
// controller state machine for the moving average block
// uses twma_pkg; drives twma_dp by command, reads its status
`default_nettype none
module twma_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic            out_busy,
    input  wire twma_pkg::stat_t st,
    output twma_pkg::cmd_t       cmd
);
    import twma_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = ST_EVICT_RD;
            end
            ST_EVICT_RD:
            begin
                if (st.period_zero)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_SCAN_INIT;
                end
                else
                begin
                    cmd.rd_oldest = 1'b1;
                    state_next    = ST_EVICT_WAIT;
                end
            end
            ST_EVICT_WAIT:
                state_next = ST_EVICT_CHK;
            ST_EVICT_CHK:
            begin
                if (st.evict_ok)
                begin
                    cmd.evict  = 1'b1;
                    state_next = ST_EVICT_RD;
                end
                else
                    state_next = ST_SCAN_INIT;
            end
            ST_SCAN_INIT:
            begin
                cmd.scan_start = 1'b1;
                cmd.div_start  = 1'b1;
                state_next     = ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                if (st.scan_done)
                    state_next = ST_DIV;
                else
                    cmd.scan_step = 1'b1;
            end
            ST_DIV:
            begin
                if (st.div_done && !out_busy)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// File: hw/rtl/twma_dp.sv
// datapath: ring memory, pointers, running sum, eviction compare, min/max scan
// uses twma_pkg and twma_div
`default_nettype none
module twma_dp #(
    parameter int CAPACITY = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire twma_pkg::cmd_t           cmd,
    output twma_pkg::stat_t               st,
    input  wire logic [31:0]              period,
    input  wire logic [31:0]              in_ts,
    input  wire logic [31:0]              in_sample,
    output logic [twma_pkg::DataW-1:0]    res_avg,
    output logic [twma_pkg::CntW-1:0]     res_count,
    output logic [twma_pkg::DataW-1:0]    res_min,
    output logic [twma_pkg::DataW-1:0]    res_max,
    output logic                          res_restart
);
    import twma_pkg::*;

    localparam int PW = $clog2(CAPACITY);
    localparam int NW = PW + 1;

    logic [63:0]   mem [CAPACITY];
    logic [63:0]   rd_data;
    logic [PW-1:0] rd_addr;
    logic          rd_en;
    logic [PW-1:0] wr_addr;

    logic [PW-1:0] old_reg, wr_reg;
    logic [SumW-1:0] sum_reg;
    logic [31:0]   ts_reg, smp_reg;
    logic          restart_reg;
    logic [PW-1:0] scan_ptr_reg;
    logic [NW-1:0] scan_left_reg;
    logic          scan_pend_reg;
    logic          scan_first_reg;
    logic          scan_go;
    logic signed [31:0] mn_reg, mx_reg;
    logic [NW-1:0] count;
    logic          div_done;
    logic [SumW-1:0] quot;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == PW'(CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        if (wr_reg >= old_reg)
            count = NW'(wr_reg - old_reg);
        else
            count = NW'(wr_reg) + NW'(CAPACITY) - NW'(old_reg);
    end

    logic signed [33:0] diff;
    assign diff = $signed({2'b00, ts_reg}) - $signed({2'b00, rd_data[63:32]});

    assign st.ring_full   = count >= NW'(CAPACITY - 1);
    assign st.period_zero = period == '0;
    assign st.empty       = count == '0;
    assign st.evict_ok    = (count != '0) && (diff >= $signed({2'b00, period}));
    assign st.scan_done   = (scan_left_reg == '0) && !scan_pend_reg;
    assign st.div_done    = div_done;

    // no read once every scan entry has been requested
    assign scan_go = cmd.scan_step && (scan_left_reg != '0);

    assign rd_en   = cmd.rd_oldest || scan_go;
    assign rd_addr = cmd.rd_oldest ? old_reg : scan_ptr_reg;
    assign wr_addr = st.ring_full ? '0 : wr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.store)
            mem[wr_addr] <= {ts_reg, smp_reg};
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            old_reg       <= '0;
            wr_reg        <= '0;
            sum_reg       <= '0;
            scan_left_reg <= '0;
            scan_pend_reg <= 1'b0;
        end
        else
        begin
            if (cmd.store)
            begin
                // full ring restarts before the new pair goes in
                if (st.ring_full)
                begin
                    old_reg <= '0;
                    wr_reg  <= PW'(1);
                    sum_reg <= SumW'($signed(smp_reg));
                end
                else
                begin
                    wr_reg  <= ring_next(wr_reg);
                    sum_reg <= sum_reg + SumW'($signed(smp_reg));
                end
            end
            if (cmd.clear)
            begin
                old_reg <= '0;
                wr_reg  <= '0;
                sum_reg <= '0;
            end
            if (cmd.evict)
            begin
                old_reg <= ring_next(old_reg);
                sum_reg <= sum_reg - SumW'($signed(rd_data[31:0]));
            end
            scan_pend_reg <= scan_go;
            if (cmd.scan_start)
                scan_left_reg <= count;
            else if (scan_go)
                scan_left_reg <= scan_left_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ts_reg  <= in_ts;
            smp_reg <= in_sample;
        end
        if (cmd.store)
            restart_reg <= st.ring_full;
        if (cmd.scan_start)
        begin
            scan_ptr_reg   <= old_reg;
            scan_first_reg <= 1'b1;
            mn_reg         <= '0;
            mx_reg         <= '0;
        end
        else
        begin
            if (scan_go)
                scan_ptr_reg <= ring_next(scan_ptr_reg);
            if (scan_pend_reg)
            begin
                scan_first_reg <= 1'b0;
                if (scan_first_reg || $signed(rd_data[31:0]) < mn_reg)
                    mn_reg <= $signed(rd_data[31:0]);
                if (scan_first_reg || $signed(rd_data[31:0]) > mx_reg)
                    mx_reg <= $signed(rd_data[31:0]);
            end
        end
    end

    twma_div #(.CW(NW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (count),
        .done     (div_done),
        .quotient (quot)
    );

    assign res_avg     = (count == '0) ? '0 : quot[DataW-1:0];
    assign res_count   = CntW'(count);
    assign res_min     = mn_reg;
    assign res_max     = mx_reg;
    assign res_restart = restart_reg;

endmodule
`default_nettype wire

// File: hw/rtl/time_window_moving_average.sv
// time window moving average: one item at a time, one result per item
// steps per item: accept, store, eviction walk (skipped with a zero period, which clears the window),
// then the min/max scan with the serial divider running alongside, then the result register load
// next item taken once the result register is loaded; the load waits while the output is stalled
// reset clears pointers, sum, period and control; ring contents undefined
`default_nettype none
module time_window_moving_average #(
    parameter int CAPACITY = 1024
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [31:0]  cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [63:0]  s_axis_tdata,   // timestamp[31:0], sample_value[63:32]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [111:0]      m_axis_tdata,   // average, sample_count, window_min, window_max
    output logic              m_axis_tuser    // window_restarted
);
    import twma_pkg::*;

    cmd_t  cmd;
    stat_t st;
    logic [31:0] period_reg;
    logic [DataW-1:0] avg, mn, mx;
    logic [CntW-1:0]  cnt;
    logic             rst_flag;
    logic             out_valid_reg;
    logic [105:0]     out_data_reg;
    logic             out_user_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= '0;
        else if (cfg_valid)
            period_reg <= cfg_data;
    end

    twma_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_busy (out_valid_reg && !m_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    twma_dp #(.CAPACITY(CAPACITY)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .period      (period_reg),
        .in_ts       (s_axis_tdata[31:0]),
        .in_sample   (s_axis_tdata[63:32]),
        .res_avg     (avg),
        .res_count   (cnt),
        .res_min     (mn),
        .res_max     (mx),
        .res_restart (rst_flag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg <= {mx, mn, cnt, avg};
            out_user_reg <= rst_flag;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_data_reg};
    assign m_axis_tuser  = out_user_reg;

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid_reg && !m_axis_tready))
        else $error("result overwritten");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item taken while busy");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.store, cmd.evict, cmd.clear}))
        else $error("conflicting pointer commands");

endmodule
`default_nettype wire

// File: test/twma_checker.sv
// checker for the time window moving average block
// watches the config, input and result channels, predicts each result and compares
// depends on nothing but the port widths and field layout of time_window_moving_average
module twma_checker #(
    parameter int CAPACITY = 1024
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic [31:0]  cfg_data,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [63:0]  s_axis_tdata,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [111:0] m_axis_tdata,
    input  wire logic         m_axis_tuser,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        restarted;
        logic [31:0] wmax;
        logic [31:0] wmin;
        logic [9:0]  count;
        logic [31:0] avg;
    } window_stats_t;

    logic [31:0]       ring_time [CAPACITY];
    logic signed [31:0] ring_val [CAPACITY];
    int unsigned       head;
    int unsigned       tail;
    longint            win_sum;
    logic [31:0]       period;
    window_stats_t     expected_stats[$];

    function automatic int unsigned ring_used();
        return (tail >= head) ? tail - head : tail + CAPACITY - head;
    endfunction

    function automatic window_stats_t next_stats(logic [31:0] ts, logic signed [31:0] sv);
        window_stats_t r;
        longint mn;
        longint mx;
        longint v;
        int unsigned n;
        int unsigned p;
        r = '0;
        if (ring_used() >= CAPACITY - 1)
        begin
            head = 0; tail = 0; win_sum = 0;
            r.restarted = 1'b1;
        end
        win_sum += sv;
        ring_time[tail] = ts;
        ring_val[tail] = sv;
        tail = (tail + 1) % CAPACITY;
        if (period == 0)
        begin
            head = 0; tail = 0; win_sum = 0;
        end
        else
            while (ring_used() != 0 &&
                   longint'(ts) - longint'(ring_time[head]) >= longint'(period))
            begin
                win_sum -= ring_val[head];
                head = (head + 1) % CAPACITY;
            end
        n = ring_used();
        r.count = n[9:0];
        if (n != 0)
        begin
            p = head;
            mn = ring_val[p];
            mx = mn;
            for (int i = 0; i < n; i++)
            begin
                v = ring_val[p];
                if (v < mn) mn = v;
                if (v > mx) mx = v;
                p = (p + 1) % CAPACITY;
            end
            r.avg = 32'(win_sum / longint'(n));
            r.wmin = 32'(mn);
            r.wmax = 32'(mx);
        end
        return r;
    endfunction

    assign pending = expected_stats.size();

    always @(posedge clk or negedge rst_n)
    begin
        window_stats_t got;
        window_stats_t want;
        if (!rst_n)
        begin
            head = 0; tail = 0; win_sum = 0; period = '0;
            fail_count <= 0;
            expected_stats.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                period = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                expected_stats.push_back(next_stats(s_axis_tdata[31:0], s_axis_tdata[63:32]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tuser, m_axis_tdata[105:0]};
                if (expected_stats.size() == 0)
                begin
                    $error("result item with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_stats.pop_front();
                    if (got != want)
                        fail_count <= fail_count + 1;
                    if (got.avg != want.avg)
                        $error("average: expected %0d got %0d",
                               $signed(want.avg), $signed(got.avg));
                    if (got.count != want.count)
                        $error("sample_count: expected %0d got %0d", want.count, got.count);
                    if (got.wmin != want.wmin)
                        $error("window_min: expected %0d got %0d",
                               $signed(want.wmin), $signed(got.wmin));
                    if (got.wmax != want.wmax)
                        $error("window_max: expected %0d got %0d",
                               $signed(want.wmax), $signed(got.wmax));
                    if (got.restarted != want.restarted)
                        $error("window_restarted: expected %0d got %0d",
                               want.restarted, got.restarted);
                end
            end
        end
    end
endmodule

// File: test/testbench.sv
// stimulus and verdict for the time window moving average block
// drives config, sample items and result back-pressure; twma_checker does the checking
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = 1024;
    localparam int IdleLimit = 20000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [31:0]  cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = '0;   // timestamp, sample_value
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;        // average, sample_count, window_min, window_max
    logic         m_axis_tuser;        // window_restarted
    int           fail_count;
    int           pending;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    bit           hold_off = 1'b0;
    int           idle_cycles = 0;
    logic [31:0]  now_ts = '0;

    always #6 clk = ~clk;

    time_window_moving_average #(.CAPACITY(CAPACITY)) i_dut (.*);

    twma_checker #(.CAPACITY(CAPACITY)) i_checker (.*);

    // result back-pressure
    always @(negedge clk)
        m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleLimit)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // valid stays high between back-to-back items
    task automatic send_sample(logic [31:0] ts, logic [31:0] sv);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tdata <= {sv, ts};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_period(logic [31:0] p);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (1200) @(negedge clk);
        cfg_data <= p;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(3))
            0: return 32'h7fff_ffff - $urandom_range(3);
            1: return 32'h8000_0000 + $urandom_range(3);
            2: return $urandom_range(200) - 100;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_run(int n, logic [31:0] max_step);
        for (int i = 0; i < n; i++)
        begin
            // mostly rising time, now and then a step backwards
            if ($urandom_range(15) == 0)
                now_ts = now_ts - $urandom_range(max_step);
            else
                now_ts = now_ts + $urandom_range(max_step);
            send_sample(now_ts, rand_sample());
        end
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero period first: those results show an empty window; then edge cases at periods 10, all ones and 1
        send_sample(32'h0, 32'h7fff_ffff);
        send_sample(32'hffff_ffff, 32'h8000_0000);
        set_period(32'd10);
        send_sample(32'd0, 32'h7fff_ffff);
        send_sample(32'd3, 32'h7fff_ffff);
        send_sample(32'd5, 32'h8000_0000);
        send_sample(32'd9, 32'hffff_ffff);
        send_sample(32'd10, 32'd7);       // evicts the first
        send_sample(32'd2, 32'd1);        // out of order, no eviction
        send_sample(32'd100, 32'hffff_fff9);
        send_sample(32'hffff_ffff, 32'h5555_aaaa);
        set_period(32'hffff_ffff);
        send_sample(32'h0, 32'haaaa_5555);
        send_sample(32'hffff_fffe, 32'h1);
        send_sample(32'hffff_ffff, 32'h2);
        set_period(32'd1);
        send_sample(32'hffff_ffff, 32'h3);
        send_sample(32'hffff_ffff, 32'h4);

        // idling phases on a mid-size window, then on a short one
        set_period(32'd500);
        send_idle_pct = 0; recv_stall_pct = 0;
        random_run(110, 32'd80);
        send_idle_pct = 54;
        random_run(110, 32'd80);
        send_idle_pct = 0; recv_stall_pct = 54;
        random_run(110, 32'd80);
        set_period(32'd3);
        send_idle_pct = 8; recv_stall_pct = 8;
        random_run(100, 32'd4);

        // long receiver hold-off while items are offered, then a long period with large time steps
        set_period(32'd0);
        send_idle_pct = 0; recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(negedge clk);
                hold_off = 1'b0;
            end
            random_run(30, 32'd10);
        join
        set_period(32'd100000);
        random_run(65, 32'h0010_0000);
        s_axis_tvalid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (1200) @(negedge clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
